>>> src/hpvt_pkg.sv
`timescale 1ns / 1ps
package hpvt_pkg;

	localparam int COORD_W    = 32;
	localparam int COORD_FRAC = 16;
	localparam int ENTRY_FRAC = 10;
	localparam int ENTRY_SLOT = 16;
	localparam int CFG_W      = 64;
	localparam int INV_W      = 48;
	localparam int CFG_IDX_W  = 3;

	localparam logic [1:0] OP_POINT  = 2'd0;
	localparam logic [1:0] OP_VECTOR = 2'd1;
	localparam logic [1:0] OP_NORMAL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW3  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_ROW0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_ROW1 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_ROW2 = 3'd6;

	localparam logic [CFG_W-1:0] MATRIX_ROW0_RST  = 64'd1024;
	localparam logic [CFG_W-1:0] MATRIX_ROW1_RST  = 64'd67108864;
	localparam logic [CFG_W-1:0] MATRIX_ROW2_RST  = 64'd4398046511104;
	localparam logic [CFG_W-1:0] MATRIX_ROW3_RST  = 64'd288230376151711744;
	localparam logic [INV_W-1:0] INVERSE_ROW0_RST = 48'd1024;
	localparam logic [INV_W-1:0] INVERSE_ROW1_RST = 48'd67108864;
	localparam logic [INV_W-1:0] INVERSE_ROW2_RST = 48'd4398046511104;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic [1:0]                op;
		logic signed [COORD_W-1:0] x_in;
		logic signed [COORD_W-1:0] y_in;
		logic signed [COORD_W-1:0] z_in;
	} hpvt_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_out;
		logic signed [COORD_W-1:0] y_out;
		logic signed [COORD_W-1:0] z_out;
		logic                      w_zero;
		logic                      saturated;
	} hpvt_out_t;

endpackage

>>> src/homogeneous_point_vector_transform.sv
`timescale 1ns / 1ps
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+--------------------------------
// command   | start, busy, cmd               | taken when start && !busy
// result    | done, result                   | one-cycle strobe, no back-pressure
// config    | cfg_we, cfg_idx, cfg_wdata     | written when cfg_we is high
//
// One word enters every cycle; busy is always low. The stages are multiply, sum
// and round, classify, one quotient bit per stage of the restoring divider, and
// the output register. The divider depth sets the latency. Reset loads identity
// matrices and clears all valid bits.
module homogeneous_point_vector_transform
	import hpvt_pkg::*;
#(
	parameter int ENTRY_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  hpvt_in_t             cmd,
	output logic                 done,
	output hpvt_out_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int CW   = COORD_W;
	localparam int EW   = ENTRY_WIDTH;
	localparam int PW   = CW + EW;
	localparam int SUMW = PW + 2;
	localparam int SW   = SUMW - ENTRY_FRAC;
	localparam int RW   = SW + 1;
	localparam int NW   = SW + COORD_FRAC;
	localparam int R0W  = NW - CW;

	localparam logic signed [SUMW-1:0] ROUND_HALF = SUMW'(1) <<< (ENTRY_FRAC - 1);
	localparam logic signed [SW-1:0]   W_ONE      = SW'(1) <<< COORD_FRAC;
	localparam logic signed [SW-1:0]   S_MAX      = SW'(COORD_MAX);
	localparam logic signed [SW-1:0]   S_MIN      = SW'(COORD_MIN);

	typedef struct packed {
		logic                           use_div;
		logic                           wz;
		logic [2:0]                     neg;
		logic [2:0]                     ovf;
		logic [2:0]                     byp_sat;
		logic [2:0][CW-1:0]             byp_val;
	} ctl_t;

	// Configuration registers.
	logic [CFG_W-1:0] fwd_q [4];
	logic [INV_W-1:0] inv_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q[0] <= MATRIX_ROW0_RST;
			fwd_q[1] <= MATRIX_ROW1_RST;
			fwd_q[2] <= MATRIX_ROW2_RST;
			fwd_q[3] <= MATRIX_ROW3_RST;
			inv_q[0] <= INVERSE_ROW0_RST;
			inv_q[1] <= INVERSE_ROW1_RST;
			inv_q[2] <= INVERSE_ROW2_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MATRIX_ROW0:  fwd_q[0] <= cfg_wdata;
				REG_MATRIX_ROW1:  fwd_q[1] <= cfg_wdata;
				REG_MATRIX_ROW2:  fwd_q[2] <= cfg_wdata;
				REG_MATRIX_ROW3:  fwd_q[3] <= cfg_wdata;
				REG_INVERSE_ROW0: inv_q[0] <= cfg_wdata[INV_W-1:0];
				REG_INVERSE_ROW1: inv_q[1] <= cfg_wdata[INV_W-1:0];
				REG_INVERSE_ROW2: inv_q[2] <= cfg_wdata[INV_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: entry selection and the twelve products.
	logic signed [CW-1:0] coord [3];
	logic signed [EW-1:0] ent   [4][3];
	logic signed [EW-1:0] trans [4];

	always_comb begin
		coord[0] = cmd.x_in;
		coord[1] = cmd.y_in;
		coord[2] = cmd.z_in;
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 3; j++) begin
				if (r < 3 && cmd.op == OP_NORMAL) begin
					ent[r][j] = inv_q[j][ENTRY_SLOT*r +: EW];
				end else begin
					ent[r][j] = fwd_q[r][ENTRY_SLOT*j +: EW];
				end
			end
			if (r == 3 || cmd.op == OP_POINT) begin
				trans[r] = fwd_q[r][ENTRY_SLOT*3 +: EW];
			end else begin
				trans[r] = '0;
			end
		end
	end

	logic                 vld_s1;
	logic [1:0]           op_s1;
	logic signed [PW-1:0] prod_s1 [4][3];
	logic signed [EW-1:0] tr_s1   [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= cmd.op;
		for (int r = 0; r < 4; r++) begin
			tr_s1[r] <= trans[r];
			for (int j = 0; j < 3; j++) begin
				prod_s1[r][j] <= ent[r][j] * coord[j];
			end
		end
	end

	// Stage 2: exact sum, rounded half up to Q24.16.
	logic signed [SUMW-1:0] sum [4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum[r] = SUMW'(prod_s1[r][0]) + SUMW'(prod_s1[r][1]) + SUMW'(prod_s1[r][2])
				+ (SUMW'(tr_s1[r]) <<< COORD_FRAC) + ROUND_HALF;
		end
	end

	logic                 vld_s2;
	logic [1:0]           op_s2;
	logic signed [SW-1:0] s_s2 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		for (int r = 0; r < 4; r++) begin
			s_s2[r] <= sum[r][SUMW-1:ENTRY_FRAC];
		end
	end

	// Stage 3: special cases of w, divider setup and the non-divide results.
	logic          w_is_zero;
	logic          w_is_one;
	logic [SW-1:0] ud;
	logic [SW-1:0] un   [3];
	logic [NW-1:0] numv [3];
	logic [CW-1:0] clamp_val [3];
	logic [2:0]    clamp_sat;
	ctl_t          ctl;

	always_comb begin
		w_is_zero = (s_s2[3] == '0);
		w_is_one  = (s_s2[3] == W_ONE);
		ud        = s_s2[3][SW-1] ? SW'(-s_s2[3]) : SW'(s_s2[3]);
		ctl       = '0;
		for (int r = 0; r < 3; r++) begin
			un[r]   = s_s2[r][SW-1] ? SW'(-s_s2[r]) : SW'(s_s2[r]);
			numv[r] = {un[r], {COORD_FRAC{1'b0}}};
			ctl.neg[r] = s_s2[r][SW-1] ^ s_s2[3][SW-1];
			// A quotient of 2^CW or more shows up as a top slice not below the divisor.
			ctl.ovf[r] = RW'(numv[r][NW-1:CW]) >= RW'(ud);
			if (s_s2[r] > S_MAX) begin
				clamp_val[r] = COORD_MAX;
				clamp_sat[r] = 1'b1;
			end else if (s_s2[r] < S_MIN) begin
				clamp_val[r] = COORD_MIN;
				clamp_sat[r] = 1'b1;
			end else begin
				clamp_val[r] = s_s2[r][CW-1:0];
				clamp_sat[r] = 1'b0;
			end
		end
		case (op_s2) inside
			OP_POINT: begin
				if (w_is_zero) begin
					ctl.wz = 1'b1;
					for (int r = 0; r < 3; r++) begin
						ctl.byp_val[r] = s_s2[r][SW-1] ? COORD_MIN : COORD_MAX;
						ctl.byp_sat[r] = 1'b1;
					end
				end else if (w_is_one) begin
					for (int r = 0; r < 3; r++) begin
						ctl.byp_val[r] = clamp_val[r];
						ctl.byp_sat[r] = clamp_sat[r];
					end
				end else begin
					ctl.use_div = 1'b1;
				end
			end
			OP_VECTOR, OP_NORMAL: begin
				for (int r = 0; r < 3; r++) begin
					ctl.byp_val[r] = clamp_val[r];
					ctl.byp_sat[r] = clamp_sat[r];
				end
			end
			default: ;
		endcase
	end

	// Divider pipeline: entry 0 is written by stage 3, entry k+1 by bit stage k.
	logic          vld_dv_s [CW+1];
	ctl_t          ctl_dv_s [CW+1];
	logic [SW-1:0] ud_dv_s  [CW+1];
	logic [RW-1:0] rem_dv_s [CW+1][3];
	logic [CW-1:0] nq_dv_s  [CW+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv_s[0] <= 1'b0;
		end else begin
			vld_dv_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctl_dv_s[0] <= ctl;
		ud_dv_s[0]  <= ud;
		for (int r = 0; r < 3; r++) begin
			rem_dv_s[0][r] <= RW'(numv[r][NW-1:CW]);
			nq_dv_s[0][r]  <= numv[r][CW-1:0];
		end
	end

	for (genvar k = 0; k < CW; k++) begin : g_div
		logic [RW-1:0] trial [3];
		logic [2:0]    ge;

		always_comb begin
			for (int r = 0; r < 3; r++) begin
				trial[r] = {rem_dv_s[k][r][RW-2:0], nq_dv_s[k][r][CW-1]};
				ge[r]    = trial[r] >= RW'(ud_dv_s[k]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv_s[k+1] <= 1'b0;
			end else begin
				vld_dv_s[k+1] <= vld_dv_s[k];
			end
		end

		// Numerator bits shift out at the top while quotient bits enter at the bottom.
		always_ff @(posedge clk) begin
			ctl_dv_s[k+1] <= ctl_dv_s[k];
			ud_dv_s[k+1]  <= ud_dv_s[k];
			for (int r = 0; r < 3; r++) begin
				rem_dv_s[k+1][r] <= ge[r] ? trial[r] - RW'(ud_dv_s[k]) : trial[r];
				nq_dv_s[k+1][r]  <= {nq_dv_s[k][r][CW-2:0], ge[r]};
			end
		end
	end

	// Sign, clamp and final select.
	ctl_t          ctl_f;
	logic [CW-1:0] qv      [3];
	logic [CW-1:0] fin_val [3];
	logic [2:0]    fin_sat;

	always_comb begin
		ctl_f = ctl_dv_s[CW];
		for (int r = 0; r < 3; r++) begin
			qv[r] = nq_dv_s[CW][r];
			if (!ctl_f.use_div) begin
				fin_val[r] = ctl_f.byp_val[r];
				fin_sat[r] = ctl_f.byp_sat[r];
			end else if (ctl_f.neg[r]) begin
				if (ctl_f.ovf[r] || (qv[r][CW-1] && |qv[r][CW-2:0])) begin
					fin_val[r] = COORD_MIN;
					fin_sat[r] = 1'b1;
				end else begin
					fin_val[r] = -qv[r];
					fin_sat[r] = 1'b0;
				end
			end else begin
				if (ctl_f.ovf[r] || qv[r][CW-1]) begin
					fin_val[r] = COORD_MAX;
					fin_sat[r] = 1'b1;
				end else begin
					fin_val[r] = qv[r];
					fin_sat[r] = 1'b0;
				end
			end
		end
	end

	logic      done_q;
	hpvt_out_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_dv_s[CW];
		end
	end

	always_ff @(posedge clk) begin
		res_q.x_out     <= fin_val[0];
		res_q.y_out     <= fin_val[1];
		res_q.z_out     <= fin_val[2];
		res_q.w_zero    <= ctl_f.wz;
		res_q.saturated <= |fin_sat;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
